### src/ms_pkg.sv
// ----------------------------------------------------------------------------
// ms_pkg
// Shared constants for the merge sorter: set depth and derived widths.
// ----------------------------------------------------------------------------
`default_nettype none

package ms_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int DATA_W       = 32;
  localparam int IDX_W        = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int SUM_W        = CNT_W + 2;
  localparam int MEM_DEPTH    = 2 * (1 << IDX_W);

endpackage

`default_nettype wire

### src/ms_if.sv
// ----------------------------------------------------------------------------
// ms_in_if / ms_out_if
// Valid/ready channels of the merge sorter: unsorted input, sorted output.
// ----------------------------------------------------------------------------
`default_nettype none

interface ms_in_if;
  import ms_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface ms_out_if;
  import ms_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value_res;
  logic                     last_res;

  modport source (output valid, output value_res, output last_res, input ready);
  modport sink   (input valid, input value_res, input last_res, output ready);
endinterface

`default_nettype wire

### src/merge_sorter.sv
// ----------------------------------------------------------------------------
// merge_sorter
// Bottom-up merge sort of up to MAX_ELEMENTS signed 32-bit values.
// ----------------------------------------------------------------------------
// Values are loaded one per cycle; values beyond MAX_ELEMENTS are dropped.
// The transfer marked last starts the sort; in_chan.ready stays low until the
// final sorted value has been transferred out. The sort runs ceil(log2(n))
// passes over a ping-pong memory (two banks of MAX_ELEMENTS words, one write
// and two registered read ports); one shared signed comparator places one
// element per S_MRD read and S_MCMP compare, each run starts in S_RUN, each
// pass in S_PASS, and a final S_PASS closes the last pass. Each output value
// is read in S_ORD and held in S_OUT until it is taken. Equal values keep
// their load order.
// ----------------------------------------------------------------------------
`default_nettype none

module merge_sorter (
  input  wire        clk,
  input  wire        rst_n,
  ms_in_if.sink      in_chan,
  ms_out_if.source   out_chan
);
  import ms_pkg::*;

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_PASS = 3'd1;
  localparam logic [2:0] S_RUN  = 3'd2;
  localparam logic [2:0] S_MRD  = 3'd3;
  localparam logic [2:0] S_MCMP = 3'd4;
  localparam logic [2:0] S_ORD  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [DATA_W-1:0] mem [0:MEM_DEPTH-1];

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [SUM_W-1:0]  w_r, w_nxt;
  logic [CNT_W-1:0]  lo_r, lo_nxt;
  logic [CNT_W-1:0]  mid_r, mid_nxt;
  logic [CNT_W-1:0]  hi_r, hi_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic              src_r, src_nxt;

  logic [DATA_W-1:0] rd_a_r, rd_b_r;
  logic              rd_a_en, rd_b_en;
  logic [IDX_W:0]    rd_a_addr, rd_b_addr;
  logic              wr_en;
  logic [IDX_W:0]    wr_addr;
  logic [DATA_W-1:0] wr_data;

  logic              in_xfer, out_xfer;
  logic [SUM_W-1:0]  n_ext, lo_ext, lo_w, lo_2w;
  logic              take_a;

  assign in_xfer  = in_chan.valid && in_chan.ready;
  assign out_xfer = out_chan.valid && out_chan.ready;
  assign n_ext    = SUM_W'(n_r);
  assign lo_ext   = SUM_W'(lo_r);
  assign lo_w     = lo_ext + w_r;
  assign lo_2w    = lo_ext + (w_r << 1);
  assign take_a   = (i_r < mid_r) &&
                    ((j_r >= hi_r) || ($signed(rd_a_r) <= $signed(rd_b_r)));

  assign in_chan.ready      = (state_r == S_LOAD);
  assign out_chan.valid     = (state_r == S_OUT);
  assign out_chan.value_res = rd_a_r;
  assign out_chan.last_res  = (SUM_W'(k_r) + SUM_W'(1)) == n_ext;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    n_nxt     = n_r;
    w_nxt     = w_r;
    lo_nxt    = lo_r;
    mid_nxt   = mid_r;
    hi_nxt    = hi_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    src_nxt   = src_r;
    rd_a_en   = 1'b0;
    rd_b_en   = 1'b0;
    rd_a_addr = {src_r, i_r[IDX_W-1:0]};
    rd_b_addr = {src_r, j_r[IDX_W-1:0]};
    wr_en     = 1'b0;
    wr_addr   = {~src_r, k_r[IDX_W-1:0]};
    wr_data   = take_a ? rd_a_r : rd_b_r;
    case (state_r)
      S_LOAD: begin
        wr_addr = {1'b0, count_r[IDX_W-1:0]};
        wr_data = in_chan.value;
        if (in_xfer) begin
          if (SUM_W'(count_r) < SUM_W'(MAX_ELEMENTS)) begin
            wr_en     = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
          if (in_chan.last) begin
            n_nxt     = count_nxt;
            count_nxt = '0;
            w_nxt     = SUM_W'(1);
            src_nxt   = 1'b0;
            state_nxt = S_PASS;
          end
        end
      end
      S_PASS: begin
        lo_nxt = '0;
        k_nxt  = '0;
        if (w_r < n_ext) begin
          state_nxt = S_RUN;
        end else begin
          state_nxt = S_ORD;
        end
      end
      S_RUN: begin
        mid_nxt   = (lo_w < n_ext) ? lo_w[CNT_W-1:0] : n_r;
        hi_nxt    = (lo_2w < n_ext) ? lo_2w[CNT_W-1:0] : n_r;
        i_nxt     = lo_r;
        j_nxt     = mid_nxt;
        k_nxt     = lo_r;
        state_nxt = S_MRD;
      end
      S_MRD: begin
        rd_a_en   = 1'b1;
        rd_b_en   = 1'b1;
        state_nxt = S_MCMP;
      end
      S_MCMP: begin
        wr_en = 1'b1;
        if (take_a) begin
          i_nxt = i_r + CNT_W'(1);
        end else begin
          j_nxt = j_r + CNT_W'(1);
        end
        k_nxt = k_r + CNT_W'(1);
        if (k_nxt == hi_r) begin
          if (lo_2w < n_ext) begin
            lo_nxt    = lo_2w[CNT_W-1:0];
            state_nxt = S_RUN;
          end else begin
            w_nxt     = w_r << 1;
            src_nxt   = ~src_r;
            state_nxt = S_PASS;
          end
        end else begin
          state_nxt = S_MRD;
        end
      end
      S_ORD: begin
        rd_a_en   = 1'b1;
        rd_a_addr = {src_r, k_r[IDX_W-1:0]};
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_xfer) begin
          if (out_chan.last_res) begin
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + CNT_W'(1);
            state_nxt = S_ORD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_a_en) begin
      rd_a_r <= mem[rd_a_addr];
    end
    if (rd_b_en) begin
      rd_b_r <= mem[rd_b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    w_r   <= w_nxt;
    lo_r  <= lo_nxt;
    mid_r <= mid_nxt;
    hi_r  <= hi_nxt;
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
    src_r <= src_nxt;
  end

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for merge_sorter: loads signed sets over the input
// channel and compares every sorted transfer against a local sort of the
// same set, with random idling on both channels and long back-pressure.
// ----------------------------------------------------------------------------

module testbench;
  import ms_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 200;
  localparam int IDLE_PCT     = 38;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 350;
  localparam int REPORT_MAX   = 10;

  localparam logic [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
  } elem_t;

  typedef enum int {
    FILL_RANDOM,
    FILL_NARROW,
    FILL_EXTREME,
    FILL_ASCEND,
    FILL_DESCEND
  } fill_e;

  logic clk;
  logic rst_n;

  ms_in_if  in_chan ();
  ms_out_if out_chan ();

  merge_sorter i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  elem_t                    pending [$];
  elem_t                    expected_out [$];
  logic signed [DATA_W-1:0] held [$];

  int unsigned errors;
  int unsigned cycles;
  bit          in_xfer;
  bit          no_idle;
  bit          hold_req;
  int          hold_cnt;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Local model: collect the set, sort it on the last transfer.
  task automatic absorb_input(input logic [DATA_W-1:0] v, input logic lst);
    logic signed [DATA_W-1:0] s [$];
    logic signed [DATA_W-1:0] t;
    int                       j;
    elem_t                    e;
    if (held.size() < MAX_ELEMENTS) held.push_back($signed(v));
    if (lst) begin
      s = held;
      for (int i = 1; i < s.size(); i++) begin
        t = s[i];
        j = i;
        while (j > 0 && s[j-1] > t) begin
          s[j] = s[j-1];
          j--;
        end
        s[j] = t;
      end
      for (int k = 0; k < s.size(); k++) begin
        e.value = s[k];
        e.last  = (k == s.size() - 1);
        expected_out.push_back(e);
      end
      held.delete();
    end
  endtask

  task automatic report_mismatch(input string what, input elem_t want, input elem_t got);
    errors++;
    if (errors <= REPORT_MAX)
      $display("MISMATCH %s: expected value %0d last %0b, got value %0d last %0b",
               what, $signed(want.value), want.last, $signed(got.value), got.last);
  endtask

  // Monitor: output check, then input prediction.
  always @(posedge clk) begin
    elem_t got;
    elem_t want;
    in_xfer = 1'b0;
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        got.value = out_chan.value_res;
        got.last  = out_chan.last_res;
        if (expected_out.size() == 0) begin
          want = '0;
          report_mismatch("unexpected transfer", want, got);
        end else begin
          want = expected_out.pop_front();
          if (got.value !== want.value) report_mismatch("value_res", want, got);
          else if (got.last !== want.last) report_mismatch("last_res", want, got);
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        in_xfer = 1'b1;
        absorb_input(in_chan.value, in_chan.last);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Driver
  always @(negedge clk) begin
    logic nv;
    nv = in_chan.valid;
    if (in_xfer) begin
      void'(pending.pop_front());
      nv = 1'b0;
    end
    if (!rst_n) begin
      nv = 1'b0;
    end else if (!nv && pending.size() > 0 &&
                 (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
      nv = 1'b1;
      in_chan.value <= pending[0].value;
      in_chan.last  <= pending[0].last;
    end
    in_chan.valid <= nv;
  end

  // Receiver, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_chan.ready <= 1'b0;
    end else if (hold_req && out_chan.valid) begin
      hold_req <= 1'b0;
      hold_cnt <= HOLD_CYCLES;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic push_item(input logic [DATA_W-1:0] v, input logic lst);
    elem_t e;
    e.value = v;
    e.last  = lst;
    pending.push_back(e);
  endtask

  function automatic logic [DATA_W-1:0] gen_value(input fill_e mode, input int idx,
                                                   input int n);
    case (mode)
      FILL_NARROW:  return 32'($urandom_range(0, 7)) - 32'd4;
      FILL_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       return WORD_MAX;
          1:       return WORD_MIN;
          2:       return '0;
          3:       return '1;
          default: return $urandom;
        endcase
      end
      FILL_ASCEND:  return 32'(idx * 3 - n);
      FILL_DESCEND: return 32'((n - idx) * 5 - 2 * n);
      default:      return $urandom;
    endcase
  endfunction

  task automatic push_set(input int n, input fill_e mode);
    for (int i = 0; i < n; i++) push_item(gen_value(mode, i, n), i == n - 1);
  endtask

  task automatic wait_drained();
    while (pending.size() != 0 || in_chan.valid) @(posedge clk);
    while (expected_out.size() != 0) @(posedge clk);
  endtask

  function automatic int random_size();
    if ($urandom_range(0, 9) == 0) return $urandom_range(17, MAX_ELEMENTS);
    return $urandom_range(1, 16);
  endfunction

  initial begin
    int    loaded;
    int    n;
    fill_e mode;
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.value  = '0;
    in_chan.last   = 1'b0;
    out_chan.ready = 1'b0;
    errors         = 0;
    cycles         = 0;
    no_idle        = 1'b0;
    hold_req       = 1'b0;
    hold_cnt       = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // single element sets, extremes with duplicates, short sets
    push_item(WORD_MIN, 1'b1);
    push_item(WORD_MAX, 1'b1);
    push_item(WORD_MAX, 1'b0);
    push_item('0, 1'b0);
    push_item(WORD_MIN, 1'b0);
    push_item('1, 1'b0);
    push_item(32'd1, 1'b0);
    push_item(WORD_MAX, 1'b0);
    push_item(WORD_MIN, 1'b0);
    push_item(32'h5555_5555, 1'b0);
    push_item(32'hAAAA_AAAA, 1'b1);
    push_item(32'd5, 1'b0);
    push_item(-32'sd5, 1'b1);
    push_set(3, FILL_NARROW);
    push_set(5, FILL_DESCEND);
    wait_drained();

    // no idling on either side
    no_idle = 1'b1;
    loaded  = 0;
    while (loaded < 60) begin
      n = random_size();
      push_set(n, FILL_RANDOM);
      loaded += n;
    end
    wait_drained();
    no_idle = 1'b0;

    // full set, then overflow: extra values and the last one are dropped
    hold_req = 1'b1;
    push_set(MAX_ELEMENTS, FILL_RANDOM);
    push_set(MAX_ELEMENTS + 6, FILL_EXTREME);
    loaded += 2 * MAX_ELEMENTS;
    while (loaded < RANDOM_ITEMS) begin
      n    = random_size();
      mode = fill_e'($urandom_range(0, 4));
      push_set(n, mode);
      loaded += n;
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
